>>> rtl/sppc_pkg.sv
// Package for the stepper position pulse controller.
// Holds the command codes, field widths, reset values and conversion constants.
// No dependencies.
package sppc_pkg;

  localparam int OP_W       = 3;
  localparam int MM_W       = 24;
  localparam int WORD_W     = 32;
  localparam int SPM_W      = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_W     = MM_W + SPM_W - 1;
  localparam int DIV_SHIFT  = 11;
  localparam int QEST_W     = 26;

  // 256000 = 2^11 * 125; the factor 125 is divided out with a reciprocal.
  localparam logic [QEST_W-1:0]  RECIP_125      = 26'd34359738;
  localparam logic [WORD_W-1:0]  DIV_ODD        = 32'd125;
  localparam logic [SPM_W-1:0]   SPM_RESET      = 20'd80000;
  localparam logic [WORD_W-1:0]  INTERVAL_RESET = 32'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_MOVE_ABS     = 3'd0,
    OP_MOVE_STEPS   = 3'd1,
    OP_SET_POSITION = 3'd2,
    OP_TICK         = 3'd3,
    OP_ENABLE       = 3'd4,
    OP_DISABLE      = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS_PER_METER  = 1'd0,
    CFG_STEP_INTERVAL_US = 1'd1
  } cfg_idx_t;

  // Load enables of the three conversion stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Fields that ride along the conversion pipeline unchanged.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] step_count;
    logic              dir_neg;
    logic [WORD_W-1:0] now_us;
  } side_t;

endpackage

>>> rtl/sppc_mm2step.sv
// Millimetre to step conversion: trunc(mm_fx * steps_per_meter / 256000).
// Three register stages: product, reciprocal estimate, correction and sign.
// Depends on sppc_pkg.
module sppc_mm2step (
  input  logic                          clk,
  input  sppc_pkg::stage_en_t           en,
  input  logic signed [sppc_pkg::MM_W-1:0]   mm_fx,
  input  logic [sppc_pkg::SPM_W-1:0]    steps_per_meter,
  output logic [sppc_pkg::WORD_W-1:0]   target
);
  import sppc_pkg::*;

  logic [MM_W-1:0]             mag;
  logic [PROD_W-1:0]           prod;
  logic                        neg1;
  logic [WORD_W-1:0]           x1;
  logic [WORD_W+QEST_W-1:0]    recip_prod;
  logic [QEST_W-1:0]           q_est;
  logic [WORD_W-1:0]           x2;
  logic                        neg2;
  logic [WORD_W-1:0]           rem;
  logic [WORD_W-1:0]           q_fix;

  // The magnitude of the most negative value is 2^23, which still fits unsigned.
  assign mag = mm_fx[MM_W-1] ? (~mm_fx + 1'b1) : mm_fx;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod <= PROD_W'(mag) * PROD_W'(steps_per_meter);
      neg1 <= mm_fx[MM_W-1];
    end
  end

  assign x1         = prod[PROD_W-1:DIV_SHIFT];
  assign recip_prod = x1 * RECIP_125;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      q_est <= recip_prod[WORD_W+QEST_W-1:WORD_W];
      x2    <= x1;
      neg2  <= neg1;
    end
  end

  // The estimate is the true quotient or one below it.
  assign rem   = x2 - WORD_W'({{(WORD_W-QEST_W){1'b0}}, q_est} * DIV_ODD);
  assign q_fix = {{(WORD_W-QEST_W){1'b0}}, q_est} + WORD_W'(rem >= DIV_ODD);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      target <= neg2 ? (~q_fix + 1'b1) : q_fix;
    end
  end

endmodule

>>> rtl/stepper_position_pulse_controller.sv
// Stepper position controller with step pulse generation, one command per word.
// Path: input register, three millimetre-to-step conversion stages and a
// result register. Throughput: one word per cycle while no stalled result
// waits at the output; the conversion pipeline moves on any bubble.
// Reset (synchronous): pipeline empty, position, count and timestamp zero,
// direction positive, driver disabled, registers at 80000 and 1000.
module stepper_position_pulse_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sppc_pkg::OP_W-1:0]            op,
  input  logic signed [sppc_pkg::MM_W-1:0]     position_mm_fx,
  input  logic [sppc_pkg::WORD_W-1:0]          step_count,
  input  logic                                 dir_neg,
  input  logic [sppc_pkg::WORD_W-1:0]          now_us,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 step_pulse,
  output logic                                 dir_level,
  output logic                                 enable_n,
  output logic [sppc_pkg::WORD_W-1:0]          steps_remaining,
  output logic signed [sppc_pkg::WORD_W-1:0]   current_position,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sppc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sppc_pkg::WORD_W-1:0]          cfg_data
);
  import sppc_pkg::*;

  logic [SPM_W-1:0]  steps_per_meter;
  logic [WORD_W-1:0] step_interval_us;

  logic              v0, v1, v2, v3;
  logic              rdy0, rdy1, rdy2, rdy3, rdy_out;
  side_t             side0, side1, side2, side3;
  logic signed [MM_W-1:0] mm0;
  logic [WORD_W-1:0] target;
  stage_en_t         conv_en;

  logic [WORD_W-1:0] position_steps, position_steps_next;
  logic [WORD_W-1:0] steps_left, steps_left_next;
  logic              moving_negative, moving_negative_next;
  logic [WORD_W-1:0] last_step_us, last_step_us_next;
  logic              driver_disabled, driver_disabled_next;
  logic              pulse_next;
  logic [WORD_W-1:0] elapsed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_meter  <= SPM_RESET;
      step_interval_us <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEPS_PER_METER:  steps_per_meter  <= cfg_data[SPM_W-1:0];
        CFG_STEP_INTERVAL_US: step_interval_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves.
  assign rdy_out  = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy_out;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_stall = !rdy0;

  assign conv_en.s1 = rdy1;
  assign conv_en.s2 = rdy2;
  assign conv_en.s3 = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy0)    v0        <= in_valid;
      if (rdy1)    v1        <= v0;
      if (rdy2)    v2        <= v1;
      if (rdy3)    v3        <= v2;
      if (rdy_out) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      side0 <= '{op: op, step_count: step_count, dir_neg: dir_neg, now_us: now_us};
      mm0   <= position_mm_fx;
    end
    if (rdy1) side1 <= side0;
    if (rdy2) side2 <= side1;
    if (rdy3) side3 <= side2;
  end

  sppc_mm2step u_mm2step (
    .clk             (clk),
    .en              (conv_en),
    .mm_fx           (mm0),
    .steps_per_meter (steps_per_meter),
    .target          (target)
  );

  assign elapsed = side3.now_us - last_step_us;

  always_comb begin
    position_steps_next  = position_steps;
    steps_left_next      = steps_left;
    moving_negative_next = moving_negative;
    last_step_us_next    = last_step_us;
    driver_disabled_next = driver_disabled;
    pulse_next           = 1'b0;
    case (op_t'(side3.op))
      OP_MOVE_ABS: begin
        if ($signed(target) > $signed(position_steps)) begin
          steps_left_next      = target - position_steps;
          moving_negative_next = 1'b0;
        end else if ($signed(target) < $signed(position_steps)) begin
          steps_left_next      = position_steps - target;
          moving_negative_next = 1'b1;
        end else begin
          steps_left_next = '0;
        end
      end
      OP_MOVE_STEPS: begin
        position_steps_next  = '0;
        moving_negative_next = side3.dir_neg;
        steps_left_next      = side3.step_count;
      end
      OP_SET_POSITION: position_steps_next = target;
      OP_TICK: begin
        if (steps_left != '0 && elapsed >= step_interval_us) begin
          pulse_next          = 1'b1;
          position_steps_next = moving_negative ? position_steps - 1'b1
                                                : position_steps + 1'b1;
          steps_left_next     = steps_left - 1'b1;
          last_step_us_next   = side3.now_us;
        end
      end
      OP_ENABLE:  driver_disabled_next = 1'b0;
      OP_DISABLE: driver_disabled_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_steps  <= '0;
      steps_left      <= '0;
      moving_negative <= 1'b0;
      last_step_us    <= '0;
      driver_disabled <= 1'b1;
    end else if (v3 && rdy_out) begin
      position_steps  <= position_steps_next;
      steps_left      <= steps_left_next;
      moving_negative <= moving_negative_next;
      last_step_us    <= last_step_us_next;
      driver_disabled <= driver_disabled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && rdy_out) begin
      step_pulse       <= pulse_next;
      dir_level        <= !moving_negative_next;
      enable_n         <= driver_disabled_next;
      steps_remaining  <= steps_left_next;
      current_position <= position_steps_next;
    end
  end

endmodule

>>> rtl/sppc_checker.sv
// Port-level checker for the stepper position pulse controller, bound to the top.
// Tracks the previous delivered word to check step pulses against state.
// No package dependency.
module sppc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        step_pulse,
  input logic        dir_level,
  input logic        enable_n,
  input logic [31:0] steps_remaining,
  input logic [31:0] current_position
);

  logic        have_prev;
  logic [31:0] prev_remaining;
  logic [31:0] prev_position;
  logic        out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_take) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      prev_remaining <= steps_remaining;
      prev_position  <= current_position;
    end
  end

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // With nothing waiting at the output, the whole pipeline can move.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(steps_remaining)
      && $stable(current_position) && $stable(step_pulse))
    else $error("stalled result changed");

  // A pulse consumes one step and moves one step in the shown direction.
  a_pulse_step: assert property (@(posedge clk) disable iff (rst)
    out_take && step_pulse && have_prev |->
      prev_remaining != 32'd0 && steps_remaining == prev_remaining - 32'd1
      && (dir_level ? current_position == prev_position + 32'd1
                    : current_position == prev_position - 32'd1))
    else $error("step pulse inconsistent with count or position");

  // On a delivered pulse, enable_n is a plain, known level.
  a_enable_level: assert property (@(posedge clk) disable iff (rst)
    out_take && step_pulse |-> !$isunknown(enable_n))
    else $error("enable level unknown on a pulse");

endmodule

bind stepper_position_pulse_controller sppc_checker u_sppc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .step_pulse       (step_pulse),
  .dir_level        (dir_level),
  .enable_n         (enable_n),
  .steps_remaining  (steps_remaining),
  .current_position (current_position)
);

>>> verif/stepper_position_pulse_controller_tb.sv
// Self-checking testbench for the stepper position pulse controller.
// Drives command words with random gaps and result stalls and checks every result word
// against a typed row or an in-bench motion predictor. Depends on sppc_pkg and RTL only.
module stepper_position_pulse_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sppc_pkg::*;

  localparam int          HALF_PERIOD     = 6;
  localparam int          RUN_LIMIT_NS    = 5_000_000;
  localparam int          ITEMS_PER_PHASE = 85;
  localparam int          PHASE_COUNT     = 6;
  localparam int          HOLD_OFF_CYCLES = 80;
  localparam int          SETTLE_CYCLES   = 12;
  localparam int          DRAIN_LIMIT     = 20000;
  localparam int          MAX_REPORTS     = 10;
  localparam logic [63:0] FX_PER_METER    = 64'd256000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MM_W-1:0]   mm;
    logic [WORD_W-1:0] cnt;
    logic              dn;
    logic [WORD_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic              pulse;
    logic              dir;
    logic              en_n;
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] pos;
  } motion_t;

  typedef struct packed {
    logic              is_cfg;
    cfg_idx_t          idx;
    logic [WORD_W-1:0] data;
    cmd_t              c;
    logic              typed;
    motion_t           want;
  } row_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [OP_W-1:0]             op;
  logic signed [MM_W-1:0]      position_mm_fx;
  logic [WORD_W-1:0]           step_count;
  logic                        dir_neg;
  logic [WORD_W-1:0]           now_us;
  logic                        out_valid;
  logic                        out_stall;
  logic                        step_pulse;
  logic                        dir_level;
  logic                        enable_n;
  logic [WORD_W-1:0]           steps_remaining;
  logic signed [WORD_W-1:0]    current_position;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [WORD_W-1:0]           cfg_data;

  // Command word on the input port, plus the typed expectation that rides with it.
  cmd_t    drv_cmd;
  logic    drv_typed;
  motion_t drv_want;

  // Predictor copy of the registers and motion state.
  logic [SPM_W-1:0]  spm_m;
  logic [WORD_W-1:0] interval_m;
  logic [WORD_W-1:0] pos_m;
  logic [WORD_W-1:0] left_m;
  logic [WORD_W-1:0] last_m;
  logic              neg_m;
  logic              dis_m;

  motion_t     motion_q[$];
  row_t        plan[$];
  int unsigned fail_count = 0;
  int unsigned result_no  = 0;
  int unsigned tx_burst   = 0;
  logic [WORD_W-1:0] tick_us = '0;
  logic        hold_off_now = 1'b0;

  assign op             = drv_cmd.op;
  assign position_mm_fx = drv_cmd.mm;
  assign step_count     = drv_cmd.cnt;
  assign dir_neg        = drv_cmd.dn;
  assign now_us         = drv_cmd.now;

  stepper_position_pulse_controller dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .position_mm_fx   (position_mm_fx),
    .step_count       (step_count),
    .dir_neg          (dir_neg),
    .now_us           (now_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .step_pulse       (step_pulse),
    .dir_level        (dir_level),
    .enable_n         (enable_n),
    .steps_remaining  (steps_remaining),
    .current_position (current_position),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Millimetres with 8 fraction bits to steps, truncated toward zero.
  function automatic logic [WORD_W-1:0] fx_to_steps(logic [MM_W-1:0] fx);
    logic [63:0] mag;
    logic [63:0] quot;
    mag  = fx[MM_W-1] ? (64'd1 << MM_W) - 64'(fx) : 64'(fx);
    quot = (mag * 64'(spm_m)) / FX_PER_METER;
    return fx[MM_W-1] ? 32'd0 - quot[WORD_W-1:0] : quot[WORD_W-1:0];
  endfunction

  function automatic motion_t advance_motion(cmd_t c);
    motion_t r;
    logic [WORD_W-1:0] tgt;
    r.pulse = 1'b0;
    case (c.op)
      OP_MOVE_ABS: begin
        tgt = fx_to_steps(c.mm);
        if ($signed(tgt) > $signed(pos_m)) begin
          left_m = tgt - pos_m;
          neg_m  = 1'b0;
        end else if ($signed(tgt) < $signed(pos_m)) begin
          left_m = pos_m - tgt;
          neg_m  = 1'b1;
        end else begin
          left_m = '0;
        end
      end
      OP_MOVE_STEPS: begin
        pos_m  = '0;
        neg_m  = c.dn;
        left_m = c.cnt;
      end
      OP_SET_POSITION: pos_m = fx_to_steps(c.mm);
      OP_TICK: begin
        if (left_m != 0 && (c.now - last_m) >= interval_m) begin
          r.pulse = 1'b1;
          pos_m   = neg_m ? pos_m - 1 : pos_m + 1;
          left_m  = left_m - 1;
          last_m  = c.now;
        end
      end
      OP_ENABLE:  dis_m = 1'b0;
      OP_DISABLE: dis_m = 1'b1;
      default: ;
    endcase
    r.dir  = ~neg_m;
    r.en_n = dis_m;
    r.left = left_m;
    r.pos  = pos_m;
    return r;
  endfunction

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want)
      note_fail($sformatf("result word %0d, %s: expected %h, got %h",
                          result_no, name, want, got));
  endfunction

  function automatic void add_cmd(cmd_t c, logic typed, motion_t want);
    row_t r;
    r       = '0;
    r.c     = c;
    r.typed = typed;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(cfg_idx_t idx, logic [WORD_W-1:0] data);
    row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    plan.push_back(r);
  endfunction

  // Mostly back-to-back words, with occasional short and rare long gaps.
  function automatic int unsigned idle_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    if (pick == 97) tx_burst = $urandom_range(20, 40);
    return $urandom_range(20, 50);
  endfunction

  // Mostly ticks paced against the step interval, so that moves actually run down.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    c.op  = OP_TICK;
    c.mm  = 24'($urandom);
    c.cnt = $urandom;
    c.dn  = 1'($urandom_range(0, 1));
    c.now = $urandom;
    pick  = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 5))
        0: c.now = tick_us;
        1: c.now = tick_us + interval_m - 1;
        2, 3: c.now = tick_us + interval_m;
        4: c.now = tick_us + interval_m + $urandom_range(1, 50);
        default: ;
      endcase
      tick_us = c.now;
    end else if (pick < 67) begin
      c.op = OP_MOVE_ABS;
      if ($urandom_range(0, 3) != 0) c.mm = 24'($urandom_range(0, 2048)) - 24'd1024;
    end else if (pick < 77) begin
      c.op = OP_MOVE_STEPS;
      if ($urandom_range(0, 4) != 0) c.cnt = $urandom_range(0, 12);
    end else if (pick < 85) begin
      c.op = OP_SET_POSITION;
      if ($urandom_range(0, 2) != 0) c.mm = 24'($urandom_range(0, 2048)) - 24'd1024;
    end else if (pick < 91) begin
      c.op = OP_ENABLE;
    end else if (pick < 97) begin
      c.op = OP_DISABLE;
    end else begin
      c.op = 3'($urandom_range(6, 7));
    end
    return c;
  endfunction

  task automatic send_cmd(cmd_t c, logic typed, motion_t want);
    int unsigned gap;
    if (tx_burst != 0) begin
      tx_burst--;
      gap = 0;
    end else begin
      gap = idle_cycles();
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drv_cmd   <= c;
    drv_typed <= typed;
    drv_want  <= want;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_STEPS_PER_METER) spm_m = data[SPM_W-1:0];
    else interval_m = data;
    @(posedge clk);
  endtask

  // Let every expected word come back, then give the pipeline time to settle.
  // It waits on the clock first so that the last accepted word is already queued.
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (motion_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Prediction on input acceptance, comparison on output acceptance.
  always @(posedge clk) begin
    motion_t model;
    motion_t got;
    motion_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        model = advance_motion(drv_cmd);
        motion_q.push_back(drv_typed ? drv_want : model);
      end
      if (out_valid && !out_stall) begin
        result_no++;
        got = {step_pulse, dir_level, enable_n, steps_remaining, current_position};
        if (motion_q.size() == 0) begin
          note_fail($sformatf("result word %0d arrived with nothing expected", result_no));
        end else begin
          want = motion_q.pop_front();
          check_field("step_pulse", 32'(want.pulse), 32'(got.pulse));
          check_field("dir_level", 32'(want.dir), 32'(got.dir));
          check_field("enable_n", 32'(want.en_n), 32'(got.en_n));
          check_field("steps_remaining", want.left, got.left);
          check_field("current_position", want.pos, got.pos);
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned pick;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_now) begin
        // Long hold-off while the sender keeps going, to back the block up.
        hold_off_now = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else if (pick < 85) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (pick < 95) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [SPM_W-1:0]  spm;
    logic [WORD_W-1:0] ivl;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    drv_cmd   <= '0;
    drv_typed <= 1'b0;
    drv_want  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_STEPS_PER_METER;
    cfg_data  <= '0;
    spm_m      = SPM_RESET;
    interval_m = INTERVAL_RESET;
    pos_m      = '0;
    left_m     = '0;
    last_m     = '0;
    neg_m      = 1'b0;
    dis_m      = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table: op, millimetres, count, negative, time.
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'd5000}, 1'b1,
            {1'b0, 1'b1, 1'b1, 32'd0, 32'd0});
    add_cmd({OP_ENABLE, 24'd0, 32'd0, 1'b0, 32'd0}, 1'b1,
            {1'b0, 1'b1, 1'b0, 32'd0, 32'd0});
    add_cmd({OP_MOVE_STEPS, 24'd0, 32'd3, 1'b0, 32'd0}, 1'b1,
            {1'b0, 1'b1, 1'b0, 32'd3, 32'd0});
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'd999}, 1'b1,
            {1'b0, 1'b1, 1'b0, 32'd3, 32'd0});
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'd1000}, 1'b1,
            {1'b1, 1'b1, 1'b0, 32'd2, 32'd1});
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'd1999}, 1'b0, '0);
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'd2000}, 1'b0, '0);
    add_cmd({OP_MOVE_ABS, 24'd256, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cmd({OP_MOVE_ABS, 24'h7FFFFF, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cmd({OP_MOVE_ABS, 24'h800000, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cmd({OP_SET_POSITION, 24'h800000, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    // Target equal to position: count cleared, direction kept negative.
    add_cmd({OP_MOVE_ABS, 24'h800000, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cmd({OP_MOVE_STEPS, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF}, 1'b1,
            {1'b0, 1'b0, 1'b0, 32'hFFFFFFFF, 32'd0});
    // Time behind the last pulse: the elapsed count wraps and the step fires.
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'h100}, 1'b0, '0);
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'hFFFFFFFF}, 1'b0, '0);
    add_cmd({3'd6, 24'h5A5A5A, 32'hA5A5A5A5, 1'b1, 32'h0F0F0F0F}, 1'b0, '0);
    add_cmd({3'd7, 24'hA5A5A5, 32'h5A5A5A5A, 1'b0, 32'hF0F0F0F0}, 1'b0, '0);
    add_cmd({OP_DISABLE, 24'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cmd({OP_SET_POSITION, 24'h7FFFFF, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cmd({OP_MOVE_ABS, 24'hFFFFFF, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cfg(CFG_STEPS_PER_METER, 32'd1048575);
    add_cmd({OP_MOVE_ABS, 24'h7FFFFF, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cfg(CFG_STEP_INTERVAL_US, 32'd0);
    add_cmd({OP_MOVE_STEPS, 24'd0, 32'd2, 1'b0, 32'd0}, 1'b1,
            {1'b0, 1'b1, 1'b1, 32'd2, 32'd0});
    // Zero interval: back-to-back ticks at the same time both step.
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cmd({OP_TICK, 24'd0, 32'd0, 1'b0, 32'd0}, 1'b0, '0);
    add_cfg(CFG_STEPS_PER_METER, 32'd0);
    add_cmd({OP_MOVE_ABS, 24'h7FFFFF, 32'd0, 1'b0, 32'd0}, 1'b0, '0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_cmd(plan[i].c, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin spm = SPM_RESET;        ivl = INTERVAL_RESET; end
        1: begin spm = 20'hFFFFF;        ivl = 32'd0; end
        2: begin spm = 20'd0;            ivl = 32'hFFFFFFFF; end
        3: begin spm = 20'd1;            ivl = 32'd1; end
        4: begin spm = 20'($urandom);    ivl = $urandom_range(0, 3000); end
        default: begin spm = 20'($urandom); ivl = $urandom; end
      endcase
      wait_idle();
      write_reg(CFG_STEPS_PER_METER, 32'(spm));
      write_reg(CFG_STEP_INTERVAL_US, ivl);
      tick_us = $urandom;
      if (p == 0) begin
        hold_off_now = 1'b1;
        tx_burst     = 40;
      end
      repeat (ITEMS_PER_PHASE) send_cmd(random_cmd(), 1'b0, '0);
    end

    wait_idle();
    if (motion_q.size() != 0)
      note_fail($sformatf("%0d expected result words never arrived", motion_q.size()));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> stepper_position_pulse_controller.f
rtl/sppc_pkg.sv
rtl/sppc_mm2step.sv
rtl/stepper_position_pulse_controller.sv
rtl/sppc_checker.sv
verif/stepper_position_pulse_controller_tb.sv
